// File: rtl/srfr_pkg.sv
// Package: constants, codes and result type for the serial reply frame receiver.
package srfr_pkg;

  localparam logic [7:0] SOF_CHAR      = 8'h23;
  localparam logic [7:0] CMD_STATUS    = 8'h42;
  localparam logic [7:0] CMD_ALT       = 8'h5A;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd4;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_REST = 2'd3;

  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;
  localparam logic [2:0] ST_DISCARDED = 3'd6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [7:0] answer_len;
    logic [2:0] status;
    logic       done_res;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       byte_valid;
  } srfr_res_t;

endpackage

// File: rtl/serial_reply_frame_receiver.sv
// Serial reply frame receiver: parses one reply frame, one item per transfer.
// A result is registered in the output register, or in the skid entry if the output stalls.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output
// stage (register plus skid) keeps the input open while one result waits.
// Reset (rst_n low, synchronous): disarmed, hunting for start, output empty.
module serial_reply_frame_receiver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // expected_cmd[7:0], buffer_capacity[23:8], timeout_ticks[39:24], rx_byte[47:40]
  input  logic [srfr_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // byte_index[7:0], out_byte[15:8], done_res[16], status[19:17],
  // answer_len[27:20], zero[31:28]
  output logic [srfr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // byte_valid[0]
  output logic                             out_tuser
);
  import srfr_pkg::*;

  logic [1:0]  req_type;
  logic [7:0]  expected_cmd;
  logic [15:0] buffer_capacity;
  logic [15:0] timeout_ticks;
  logic [7:0]  rx_byte;

  logic        active_r, active_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  got_cmd_r, got_cmd_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic        ignore_frame_r, ignore_frame_nxt;
  logic [7:0]  want_cmd_r, want_cmd_nxt;
  logic [15:0] capacity_r, capacity_nxt;
  logic [15:0] timeout_load_r, timeout_load_nxt;
  logic [15:0] ticks_left_r, ticks_left_nxt;

  srfr_res_t   res;
  srfr_res_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;
  logic        in_acc, out_fire;
  logic [7:0]  count_inc;
  logic [15:0] ticks_dec;
  logic        cmd_ok, cmd_ign;

  assign req_type        = in_tuser;
  assign expected_cmd    = in_tdata[7:0];
  assign buffer_capacity = in_tdata[23:8];
  assign timeout_ticks   = in_tdata[39:24];
  assign rx_byte         = in_tdata[47:40];

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  assign count_inc = byte_count_r + 8'd1;
  assign ticks_dec = (ticks_left_r != 16'd0) ? ticks_left_r - 16'd1 : ticks_left_r;

  always_comb begin
    cmd_ok  = 1'b0;
    cmd_ign = 1'b0;
    if (want_cmd_r == CMD_STATUS) begin
      cmd_ok = (rx_byte == CMD_STATUS) || (rx_byte == CMD_ALT);
    end else if (rx_byte == want_cmd_r) begin
      cmd_ok = 1'b1;
    end else if ((rx_byte == CMD_STATUS) || (rx_byte == CMD_ALT)) begin
      cmd_ok  = 1'b1;
      cmd_ign = 1'b1;
    end
  end

  always_comb begin
    active_nxt       = active_r;
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_len_nxt    = frame_len_r;
    got_cmd_nxt      = got_cmd_r;
    running_sum_nxt  = running_sum_r;
    ignore_frame_nxt = ignore_frame_r;
    want_cmd_nxt     = want_cmd_r;
    capacity_nxt     = capacity_r;
    timeout_load_nxt = timeout_load_r;
    ticks_left_nxt   = ticks_left_r;
    res              = '0;

    if (req_type == REQ_START) begin
      phase_nxt        = PH_HUNT;
      byte_count_nxt   = '0;
      frame_len_nxt    = '0;
      got_cmd_nxt      = '0;
      running_sum_nxt  = '0;
      ignore_frame_nxt = 1'b0;
      want_cmd_nxt     = expected_cmd;
      capacity_nxt     = buffer_capacity;
      timeout_load_nxt = timeout_ticks;
      ticks_left_nxt   = timeout_ticks;
      active_nxt       = 1'b1;
      if (timeout_ticks == 16'd0) begin
        res.done_res = 1'b1;
        res.status   = ST_TIMEOUT;
        active_nxt   = 1'b0;
      end
    end else if (active_r && req_type == REQ_TICK) begin
      ticks_left_nxt = ticks_dec;
      if (ticks_dec == 16'd0) begin
        res.done_res = 1'b1;
        res.status   = ST_TIMEOUT;
        active_nxt   = 1'b0;
      end
    end else if (active_r && req_type == REQ_BYTE) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == SOF_CHAR) begin
            res.byte_valid  = 1'b1;
            res.byte_index  = 8'd0;
            res.out_byte    = rx_byte;
            running_sum_nxt = rx_byte;
            byte_count_nxt  = 8'd1;
            phase_nxt       = PH_CMD;
          end
        end
        PH_CMD: begin
          if (cmd_ok) begin
            res.byte_valid   = 1'b1;
            res.byte_index   = 8'd1;
            res.out_byte     = rx_byte;
            ignore_frame_nxt = cmd_ign;
            got_cmd_nxt      = rx_byte;
            running_sum_nxt  = running_sum_r + rx_byte;
            byte_count_nxt   = 8'd2;
            phase_nxt        = PH_LEN;
          end else begin
            phase_nxt        = PH_HUNT;
            byte_count_nxt   = '0;
            frame_len_nxt    = '0;
            got_cmd_nxt      = '0;
            running_sum_nxt  = '0;
            ignore_frame_nxt = 1'b0;
          end
        end
        PH_LEN: begin
          if (capacity_r < {8'd0, rx_byte}) begin
            res.done_res = 1'b1;
            res.status   = ST_TOO_LONG;
            active_nxt   = 1'b0;
          end else if (rx_byte < MIN_FRAME_LEN) begin
            res.done_res = 1'b1;
            res.status   = ST_TOO_SHORT;
            active_nxt   = 1'b0;
          end else begin
            res.byte_valid  = 1'b1;
            res.byte_index  = 8'd2;
            res.out_byte    = rx_byte;
            frame_len_nxt   = rx_byte;
            running_sum_nxt = running_sum_r + rx_byte;
            byte_count_nxt  = 8'd3;
            phase_nxt       = PH_REST;
          end
        end
        default: begin
          res.byte_valid = 1'b1;
          res.byte_index = byte_count_r;
          res.out_byte   = rx_byte;
          byte_count_nxt = count_inc;
          if (count_inc >= frame_len_r) begin
            if (rx_byte == running_sum_r) begin
              if (ignore_frame_r) begin
                res.status       = ST_DISCARDED;
                phase_nxt        = PH_HUNT;
                byte_count_nxt   = '0;
                frame_len_nxt    = '0;
                got_cmd_nxt      = '0;
                running_sum_nxt  = '0;
                ignore_frame_nxt = 1'b0;
                ticks_left_nxt   = timeout_load_r;
              end else begin
                res.answer_len = frame_len_r;
                res.done_res   = 1'b1;
                res.status     = ST_OK;
                active_nxt     = 1'b0;
              end
            end else begin
              res.done_res = 1'b1;
              res.status   = ST_BAD_SUM;
              active_nxt   = 1'b0;
            end
          end else begin
            running_sum_nxt = running_sum_r + rx_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      phase_r        <= PH_HUNT;
      byte_count_r   <= '0;
      frame_len_r    <= '0;
      got_cmd_r      <= '0;
      running_sum_r  <= '0;
      ignore_frame_r <= 1'b0;
      want_cmd_r     <= '0;
      capacity_r     <= '0;
      timeout_load_r <= '0;
      ticks_left_r   <= '0;
    end else if (in_acc) begin
      active_r       <= active_nxt;
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_len_r    <= frame_len_nxt;
      got_cmd_r      <= got_cmd_nxt;
      running_sum_r  <= running_sum_nxt;
      ignore_frame_r <= ignore_frame_nxt;
      want_cmd_r     <= want_cmd_nxt;
      capacity_r     <= capacity_nxt;
      timeout_load_r <= timeout_load_nxt;
      ticks_left_r   <= ticks_left_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.byte_valid;
  assign out_tdata  = {4'd0, out_r.answer_len, out_r.status, out_r.done_res,
                       out_r.out_byte, out_r.byte_index};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.done_res) |=> !active_r)
    else $error("receiver still armed after final status");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OK) |->
      (out_r.answer_len >= MIN_FRAME_LEN && out_r.done_res && out_r.byte_valid))
    else $error("ok status with bad length or flags");

  a_idle_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !active_r && req_type != REQ_START) |-> (res == '0))
    else $error("result produced while disarmed");

endmodule
